>>> sv/tmwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter package
// Shared sample type, stage load struct and divide-by-three constants.
// ----------------------------------------------------------------------------
package tmwf_pkg;

  localparam int DATA_W = 32;
  localparam int SUM_W  = DATA_W + 2;   // exact sum of three samples
  localparam int MAG_W  = DATA_W + 1;   // magnitude of that sum
  localparam int RECIP_W = 32;
  localparam int PROD_W = MAG_W + RECIP_W;

  // ceil(2^33 / 3): exact quotient for every magnitude below 2^33.
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 32'hAAAA_AAAB;
  localparam int DIV3_SHIFT = 33;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Load strobes of the four datapath stages, starting with the cell row.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } tmwf_stage_en_t;

endpackage

>>> sv/tmwf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter cell
// One window position: holds a history tap, passes it to its older neighbor
// on every accepted item and registers its value with its rank in the window.
// ----------------------------------------------------------------------------
module tmwf_cell #(
  parameter int WINDOW = 5,
  parameter int POS    = 0,
  parameter int RANK_W = $clog2(WINDOW)
) (
  input  logic                  clk,
  input  logic                  shift,
  input  tmwf_pkg::sample_t     din,
  input  tmwf_pkg::sample_t     win [WINDOW],
  output tmwf_pkg::sample_t     q,
  output tmwf_pkg::sample_t     val,
  output logic [RANK_W-1:0]     rank
);
  import tmwf_pkg::*;

  logic [RANK_W-1:0] rank_next;

  // The newest position is the incoming sample itself; older ones are taps.
  generate
    if (POS == WINDOW - 1) begin : g_live
      assign q = din;
    end else begin : g_tap
      sample_t tap;
      always_ff @(posedge clk) begin
        if (shift) begin
          tap <= din;
        end
      end
      assign q = tap;
    end
  endgenerate

  // Equal values are ordered by position, so the ranks form a permutation.
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (j < POS) begin
        if (win[j] <= q) rank_next = rank_next + RANK_W'(1);
      end else if (j > POS) begin
        if (win[j] < q) rank_next = rank_next + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val  <= q;
      rank <= rank_next;
    end
  end

endmodule

>>> sv/tmwf_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter axis lane
// Row of cells for one axis, then selection of the three middle ranks,
// exact sum, magnitude, reciprocal multiply and sign restore.
// ----------------------------------------------------------------------------
module tmwf_axis #(
  parameter int WINDOW = 5
) (
  input  logic                     clk,
  input  tmwf_pkg::tmwf_stage_en_t en,
  input  tmwf_pkg::sample_t        sample,
  output tmwf_pkg::sample_t        mean
);
  import tmwf_pkg::*;

  localparam int RANK_W = $clog2(WINDOW);
  localparam int CENTER = (WINDOW - 1) / 2;

  sample_t           win   [WINDOW];
  sample_t           val1  [WINDOW];
  logic [RANK_W-1:0] rank1 [WINDOW];
  sample_t           sel   [3];

  logic signed [SUM_W-1:0] sum2;
  logic signed [SUM_W-1:0] sum_next;
  logic [MAG_W-1:0]        mag3;
  logic                    neg3;
  logic [PROD_W-1:0]       prod;
  logic [DATA_W-1:0]       quot4;
  logic                    neg4;

  // Oldest sample sits in cell 0; each cell loads from its newer neighbor.
  generate
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      tmwf_cell #(.WINDOW(WINDOW), .POS(k), .RANK_W(RANK_W)) u_cell (
        .clk   (clk),
        .shift (en.ld1),
        .din   ((k == WINDOW - 1) ? sample : win[(k + 1) % WINDOW]),
        .win   (win),
        .q     (win[k]),
        .val   (val1[k]),
        .rank  (rank1[k])
      );
    end
  endgenerate

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      sel[t] = '0;
    end
    for (int k = 0; k < WINDOW; k++) begin
      for (int t = 0; t < 3; t++) begin
        if (rank1[k] == RANK_W'(CENTER - 1 + t)) sel[t] = sel[t] | val1[k];
      end
    end
    sum_next = SUM_W'(sel[0]) + SUM_W'(sel[1]) + SUM_W'(sel[2]);
  end

  assign prod = PROD_W'(mag3) * PROD_W'(DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      sum2 <= sum_next;
    end
    if (en.ld3) begin
      neg3 <= sum2[SUM_W-1];
      mag3 <= sum2[SUM_W-1] ? MAG_W'(-sum2) : MAG_W'(sum2);
    end
    if (en.ld4) begin
      neg4  <= neg3;
      quot4 <= prod[DIV3_SHIFT +: DATA_W];
    end
  end

  // Quotient of the magnitude, negated back: truncation toward zero.
  assign mean = neg4 ? sample_t'(-quot4) : sample_t'(quot4);

endmodule

>>> sv/trimmed_mean_window_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter
// Three-axis sliding window; each result is the mean of the median and its
// two neighbors once the window is full, the held value before that.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  -----------------------------------------
//   input    in_valid / in_ready   sample_x, sample_y, sample_z
//   output   out_valid / out_ready filtered_x, filtered_y, filtered_z,
//                                  window_full
//
// One item is accepted per clock while in_ready is high; its result passes
// the rank, select and sum, magnitude and multiply stages into the output
// register, from which it leaves. The rank compare in the cell row and the
// 33 x 32 reciprocal multiply set those stages. Reset clears the fill count,
// the stage valid bits and the held result, and keeps in_ready low. A stalled
// output only backs up the stages that are full; empty stages keep taking
// items.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter #(
  parameter int WINDOW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmwf_pkg::sample_t sample_x,
  input  tmwf_pkg::sample_t sample_y,
  input  tmwf_pkg::sample_t sample_z,
  output logic              out_valid,
  input  logic              out_ready,
  output tmwf_pkg::sample_t filtered_x,
  output tmwf_pkg::sample_t filtered_y,
  output tmwf_pkg::sample_t filtered_z,
  output logic              window_full
);
  import tmwf_pkg::*;

  // The fill count runs from zero to WINDOW-1 stored samples.
  localparam int CNT_W = $clog2(WINDOW);

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             full0;

  tmwf_stage_en_t en;
  logic v1, v2, v3, v4;
  logic f1, f2, f3, f4;
  logic ld_out;
  logic rdy2, rdy3, rdy4;

  sample_t mean_x, mean_y, mean_z;

  // Each stage takes a new item when it is empty or its item moves on.
  always_comb begin
    ld_out = v4 & (~out_valid | out_ready);
    rdy4   = ~v4 | ld_out;
    en.ld4 = v3 & rdy4;
    rdy3   = ~v3 | en.ld4;
    en.ld3 = v2 & rdy3;
    rdy2   = ~v2 | en.ld3;
    en.ld2 = v1 & rdy2;
    in_ready = ~rst & (~v1 | en.ld2);
    en.ld1 = in_valid & in_ready;
  end

  // The window is full when all WINDOW-1 history taps have been written.
  assign full0 = (fill_count == CNT_W'(WINDOW - 1));
  assign fill_count_next = (en.ld1 && !full0) ? fill_count + CNT_W'(1) : fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      v1 <= en.ld1 | (v1 & ~en.ld2);
      v2 <= en.ld2 | (v2 & ~en.ld3);
      v3 <= en.ld3 | (v3 & ~en.ld4);
      v4 <= en.ld4 | (v4 & ~ld_out);
      out_valid <= ld_out | (out_valid & ~out_ready);
    end
  end

  // The full flag travels beside the datapath.
  always_ff @(posedge clk) begin
    if (en.ld1) f1 <= full0;
    if (en.ld2) f2 <= f1;
    if (en.ld3) f3 <= f2;
    if (en.ld4) f4 <= f3;
  end

  // The output register doubles as the held result: an item from a window
  // that is not yet full leaves it unchanged, and reset clears it to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_x  <= '0;
      filtered_y  <= '0;
      filtered_z  <= '0;
      window_full <= 1'b0;
    end else if (ld_out) begin
      window_full <= f4;
      if (f4) begin
        filtered_x <= mean_x;
        filtered_y <= mean_y;
        filtered_z <= mean_z;
      end
    end
  end

  tmwf_axis #(.WINDOW(WINDOW)) u_axis_x (
    .clk    (clk),
    .en     (en),
    .sample (sample_x),
    .mean   (mean_x)
  );

  tmwf_axis #(.WINDOW(WINDOW)) u_axis_y (
    .clk    (clk),
    .en     (en),
    .sample (sample_y),
    .mean   (mean_y)
  );

  tmwf_axis #(.WINDOW(WINDOW)) u_axis_z (
    .clk    (clk),
    .en     (en),
    .sample (sample_z),
    .mean   (mean_z)
  );

endmodule

>>> sv/tmwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter checker
// Port-level checks of the output channel and of the window fill sequence.
// ----------------------------------------------------------------------------
module tmwf_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input tmwf_pkg::sample_t filtered_x,
  input tmwf_pkg::sample_t filtered_y,
  input tmwf_pkg::sample_t filtered_z,
  input logic              window_full
);
  import tmwf_pkg::*;

  logic seen_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_full <= 1'b0;
    end else if (out_valid && out_ready && window_full) begin
      seen_full <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(filtered_x) && $stable(filtered_y) &&
      $stable(filtered_z) && $stable(window_full))
    else $error("stalled output item changed");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_full |-> filtered_x == 0 && filtered_y == 0 &&
      filtered_z == 0)
    else $error("result before a full window is not zero");

  a_full_stays: assert property (@(posedge clk) disable iff (rst)
    seen_full && out_valid |-> window_full)
    else $error("window reported not full after it had filled");

endmodule

bind trimmed_mean_window_filter tmwf_checker u_tmwf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .filtered_x  (filtered_x),
  .filtered_y  (filtered_y),
  .filtered_z  (filtered_z),
  .window_full (window_full)
);
